FILE: src/rssc_pkg.sv
// Shared types and constants for the run-length sprite span compositor.
// Used by every module of the block; has no dependencies of its own.
package rssc_pkg;

   // Clamp limits for the sprite size registers.
   localparam logic [9:0] MAX_WIDTH  = 10'd640;
   localparam logic [8:0] MAX_HEIGHT = 9'd480;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Run status codes as they arrive on the input channel.
   localparam logic [1:0] ST_MORE = 2'd0;  // pixels left in line
   localparam logic [1:0] ST_EOL  = 2'd1;  // end of line
   localparam logic [1:0] ST_EOS  = 2'd2;  // end of sprite
   localparam logic [1:0] ST_RSVD = 2'd3;  // unused, treated as pixels left

   // Span kinds on the result channel.
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_SHADOW = 2'd2;

   // Transparent code of 256-color sprites.
   localparam logic [7:0] FULL_TRANSPARENT = 8'hFF;

   // Configuration register indexes.
   localparam logic [2:0] REG_MIRROR     = 3'd0;
   localparam logic [2:0] REG_FULL_COLOR = 3'd1;
   localparam logic [2:0] REG_SHADOW     = 3'd2;
   localparam logic [2:0] REG_BASE_COLOR = 3'd3;
   localparam logic [2:0] REG_WIDTH      = 3'd4;
   localparam logic [2:0] REG_HEIGHT     = 3'd5;
   localparam logic [2:0] REG_SKIP       = 3'd6;

   // Configuration register contents.
   typedef struct packed {
      logic       mirror;
      logic       full_color;
      logic       shadow_mode;
      logic [7:0] base_color;
      logic [9:0] span_width;
      logic [8:0] span_height;
      logic [9:0] skip_columns;
   } rssc_cfg_type;

   // A classified run as it waits in the queue.
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] run_count;
      logic [1:0] kind;
      logic [7:0] color;
   } rssc_item_type;

endpackage

FILE: src/rssc_front.sv
// Front part: classifies an incoming run packet (opacity, kind, color, status).
// Depends on rssc_pkg.
module rssc_front import rssc_pkg::*; (
   input  rssc_cfg_type  cfg,
   input  logic [7:0]    pixel_value,
   input  logic [7:0]    run_count,
   input  logic [1:0]    run_status,
   output rssc_item_type item
);

   logic opaque;

   // A run is opaque unless transparent in its mode; 256-color shadow has none.
   assign opaque = (cfg.shadow_mode && (pixel_value != 8'h00)) ||
                   (cfg.full_color && (pixel_value != FULL_TRANSPARENT)) ||
                   (!cfg.full_color && (pixel_value != 8'h00));

   // Kind and color; shadow mode takes priority over the color modes.
   always_comb begin
      item.run_count = run_count;
      item.kind      = KIND_NONE;
      item.color     = 8'h00;
      if (opaque) begin
         if (cfg.shadow_mode) begin
            item.kind = KIND_SHADOW;
         end else begin
            item.kind = KIND_WRITE;
            if (cfg.full_color) begin
               item.color = {pixel_value[3:0], pixel_value[7:4]};
            end else begin
               item.color = pixel_value + cfg.base_color - 8'd1;
            end
         end
      end
      // The reserved status code behaves as pixels left in line.
      unique case (run_status)
         ST_EOL:           item.status = ST_EOL;
         ST_EOS:           item.status = ST_EOS;
         ST_MORE, ST_RSVD: item.status = ST_MORE;
         default:          item.status = ST_MORE;
      endcase
   end

endmodule

FILE: src/rssc_queue.sv
// Short queue of classified runs between the front and back parts.
// Depends on rssc_pkg.
module rssc_queue import rssc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rssc_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output rssc_item_type head_item,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] level
);

   localparam int PtrWidth   = $clog2(QUEUE_DEPTH);
   localparam int LevelWidth = $clog2(QUEUE_DEPTH + 1);

   rssc_item_type               entry_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [LevelWidth-1:0]       count_ff, count_in;

   assign full      = (count_ff == LevelWidth'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];
   assign level     = count_ff;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/rssc_back.sv
// Back part: tracks clipping, width, lines and column, and registers one span
// per run. Depends on rssc_pkg.
module rssc_back import rssc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  rssc_cfg_type  cfg,
   input  logic          item_valid,
   input  rssc_item_type item,
   output logic          item_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [8:0]    line_index,
   output logic [9:0]    start_column,
   output logic [7:0]    span_length,
   output logic [7:0]    color_value,
   output logic [1:0]    span_kind,
   output logic          sprite_done
);

   // Sprite walk state.
   logic [9:0] skip_left_ff, skip_left_in;
   logic [9:0] width_left_ff, width_left_in;
   logic [8:0] lines_left_ff, lines_left_in;
   logic [8:0] current_line_ff, current_line_in;
   logic [9:0] column_pos_ff, column_pos_in;
   logic       draining_ff, draining_in;
   logic       finished_ff, finished_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [8:0] line_ff, line_in;
   logic [9:0] column_ff, column_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] color_ff, color_in;
   logic [1:0] kind_ff, kind_in;
   logic       done_ff, done_in;

   // Values loaded at a line start.
   logic [9:0] width_clamp;
   logic [8:0] height_clamp;
   logic [9:0] load_column;

   // State as seen by the current run, after a possible sprite start.
   logic [9:0] eff_skip;
   logic [9:0] eff_width;
   logic [8:0] eff_lines;
   logic [8:0] eff_line;
   logic [9:0] eff_column;
   logic       eff_draining;

   logic       skip_hit;
   logic [7:0] net_count;
   logic [7:0] run_len;
   logic [9:0] width_after;
   logic       end_line;
   logic       done;

   assign width_clamp  = (cfg.span_width > MAX_WIDTH) ? MAX_WIDTH : cfg.span_width;
   assign height_clamp = (cfg.span_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg.span_height;
   assign load_column  = cfg.mirror ? width_clamp : 10'd0;

   // A run arriving after the sprite finished starts a new one.
   always_comb begin
      if (finished_ff) begin
         eff_skip     = cfg.skip_columns;
         eff_width    = width_clamp;
         eff_lines    = height_clamp;
         eff_line     = 9'd0;
         eff_column   = load_column;
         eff_draining = 1'b0;
      end else begin
         eff_skip     = skip_left_ff;
         eff_width    = width_left_ff;
         eff_lines    = lines_left_ff;
         eff_line     = current_line_ff;
         eff_column   = column_pos_ff;
         eff_draining = draining_ff;
      end
   end

   // Clipping and clamping of the run. When the run passes the clip, the
   // remaining skip is below the count and so fits in eight bits.
   assign skip_hit    = (eff_skip != 10'd0) && ({2'b00, item.run_count} <= eff_skip);
   assign net_count   = item.run_count - eff_skip[7:0];
   assign run_len     = ({2'b00, net_count} < eff_width) ? net_count : eff_width[7:0];
   assign width_after = eff_width - {2'b00, run_len};

   // Line end decision for draining and drawing runs.
   always_comb begin
      if (eff_draining) begin
         end_line = (item.status != ST_MORE);
      end else if (skip_hit) begin
         end_line = 1'b0;
      end else begin
         end_line = (width_after == 10'd0 && item.status != ST_MORE) ||
                    (width_after != 10'd0 && item.status != ST_MORE);
      end
   end

   assign done = end_line && ((item.status == ST_EOS) || (eff_lines <= 9'd1));

   // A run is taken when the output register is free or being emptied.
   assign item_pop = item_valid && (!rsp_valid_ff || rsp_ready);

   // Next state and next output.
   always_comb begin
      skip_left_in    = skip_left_ff;
      width_left_in   = width_left_ff;
      lines_left_in   = lines_left_ff;
      current_line_in = current_line_ff;
      column_pos_in   = column_pos_ff;
      draining_in     = draining_ff;
      finished_in     = finished_ff;
      line_in         = line_ff;
      column_in       = column_ff;
      length_in       = length_ff;
      color_in        = color_ff;
      kind_in         = kind_ff;
      done_in         = done_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      if (item_pop) begin
         rsp_valid_in    = 1'b1;
         skip_left_in    = eff_skip;
         width_left_in   = eff_width;
         lines_left_in   = eff_lines;
         current_line_in = eff_line;
         column_pos_in   = eff_column;
         draining_in     = eff_draining;
         finished_in     = 1'b0;
         line_in         = eff_line;
         column_in       = eff_column;
         length_in       = 8'd0;
         color_in        = 8'h00;
         kind_in         = KIND_NONE;
         done_in         = done;
         if (!eff_draining) begin
            if (skip_hit) begin
               skip_left_in = eff_skip - {2'b00, item.run_count};
            end else begin
               // Drawing run: clamp, advance the column, maybe start draining.
               skip_left_in  = 10'd0;
               width_left_in = width_after;
               length_in     = run_len;
               color_in      = item.color;
               kind_in       = item.kind;
               column_pos_in = cfg.mirror ? eff_column - {2'b00, run_len}
                                          : eff_column + {2'b00, run_len};
               if (width_after == 10'd0 && item.status == ST_MORE) begin
                  draining_in = 1'b1;
               end
            end
         end
         // Line advance reloads the per-line values from the registers.
         if (end_line) begin
            lines_left_in   = (eff_lines != 9'd0) ? eff_lines - 9'd1 : 9'd0;
            current_line_in = eff_line + 9'd1;
            skip_left_in    = cfg.skip_columns;
            width_left_in   = width_clamp;
            column_pos_in   = load_column;
            draining_in     = 1'b0;
            finished_in     = done;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_left_ff    <= 10'd0;
         width_left_ff   <= 10'd0;
         lines_left_ff   <= 9'd0;
         current_line_ff <= 9'd0;
         column_pos_ff   <= 10'd0;
         draining_ff     <= 1'b0;
         finished_ff     <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         skip_left_ff    <= skip_left_in;
         width_left_ff   <= width_left_in;
         lines_left_ff   <= lines_left_in;
         current_line_ff <= current_line_in;
         column_pos_ff   <= column_pos_in;
         draining_ff     <= draining_in;
         finished_ff     <= finished_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Output payload needs no reset.
   always_ff @(posedge clock) begin
      line_ff   <= line_in;
      column_ff <= column_in;
      length_ff <= length_in;
      color_ff  <= color_in;
      kind_ff   <= kind_in;
      done_ff   <= done_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign line_index   = line_ff;
   assign start_column = column_ff;
   assign span_length  = length_ff;
   assign color_value  = color_ff;
   assign span_kind    = kind_ff;
   assign sprite_done  = done_ff;

endmodule

FILE: src/rle_sprite_span_compositor.sv
// Run-length sprite span compositor: one span result per run packet.
// A beat accepted on the input passes the queue and then the back part's output register.
// Throughput: one beat per cycle while the result side takes every beat.
// A two-entry queue parts input and result sides, so either may stall on its own.
// Reset (synchronous): queue empty, no result, sprite finished, registers at defaults.
module rle_sprite_span_compositor import rssc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] pixel_value, [15:8] run_count
   input  logic [1:0]  req_tuser,   // [1:0] run_status
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [8:0] line_index, [18:9] start_column,
                                    // [26:19] span_length, [34:27] color_value, zeros
   output logic [1:0]  rsp_tuser,   // [1:0] span_kind
   output logic        rsp_tlast,   // sprite_done
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   rssc_cfg_type  cfg_ff, cfg_in;
   rssc_item_type front_item;
   rssc_item_type head_item;
   logic          queue_full;
   logic          queue_not_empty;
   logic          queue_pop;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_level;
   logic          cfg_write;
   logic [2:0]    cfg_index;
   logic [8:0]    line_index;
   logic [9:0]    start_column;
   logic [7:0]    span_length;
   logic [7:0]    color_value;

   // Register file writes.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_index  = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (cfg_index)
            REG_MIRROR:     cfg_in.mirror       = csr_pwdata[0];
            REG_FULL_COLOR: cfg_in.full_color   = csr_pwdata[0];
            REG_SHADOW:     cfg_in.shadow_mode  = csr_pwdata[0];
            REG_BASE_COLOR: cfg_in.base_color   = csr_pwdata[7:0];
            REG_WIDTH:      cfg_in.span_width   = csr_pwdata[9:0];
            REG_HEIGHT:     cfg_in.span_height  = csr_pwdata[8:0];
            REG_SKIP:       cfg_in.skip_columns = csr_pwdata[9:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mirror       <= 1'b0;
         cfg_ff.full_color   <= 1'b0;
         cfg_ff.shadow_mode  <= 1'b0;
         cfg_ff.base_color   <= 8'd0;
         cfg_ff.span_width   <= 10'd1;
         cfg_ff.span_height  <= 9'd1;
         cfg_ff.skip_columns <= 10'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register file reads.
   always_comb begin
      csr_prdata = 32'd0;
      case (cfg_index)
         REG_MIRROR:     csr_prdata = {31'd0, cfg_ff.mirror};
         REG_FULL_COLOR: csr_prdata = {31'd0, cfg_ff.full_color};
         REG_SHADOW:     csr_prdata = {31'd0, cfg_ff.shadow_mode};
         REG_BASE_COLOR: csr_prdata = {24'd0, cfg_ff.base_color};
         REG_WIDTH:      csr_prdata = {22'd0, cfg_ff.span_width};
         REG_HEIGHT:     csr_prdata = {23'd0, cfg_ff.span_height};
         REG_SKIP:       csr_prdata = {22'd0, cfg_ff.skip_columns};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // Front part classifies each beat as it is accepted.
   rssc_front u_front (
      .cfg         (cfg_ff),
      .pixel_value (req_tdata[7:0]),
      .run_count   (req_tdata[15:8]),
      .run_status  (req_tuser),
      .item        (front_item)
   );

   assign req_tready = !queue_full;

   rssc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && !queue_full),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head_item (head_item),
      .level     (queue_level)
   );

   // Back part walks the sprite and holds the result beat.
   rssc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .item_valid   (queue_not_empty),
      .item         (head_item),
      .item_pop     (queue_pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .line_index   (line_index),
      .start_column (start_column),
      .span_length  (span_length),
      .color_value  (color_value),
      .span_kind    (rsp_tuser),
      .sprite_done  (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, color_value, span_length, start_column, line_index};

   // A span that writes nothing carries no color.
   a_no_color_without_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != KIND_WRITE) |-> (rsp_tdata[34:27] == 8'h00))
      else $error("color present on a span that writes nothing");

   // The input side stalls only while the queue is full.
   a_ready_tracks_queue: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (queue_level == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
      else $error("input stalled with room in the queue");

   // A run leaves the queue only when one was waiting, and then a result follows.
   a_pop_gives_result: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> (queue_not_empty ##1 rsp_tvalid))
      else $error("run taken from the queue without a result");

endmodule

FILE: dv/rle_sprite_span_compositor_checker.sv
// Span checker for the run-length sprite span compositor: predicts every span and compares it.
// Watches the run, span and register channels of the block; depends on rssc_pkg only.
module rle_sprite_span_compositor_checker import rssc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] pixel_value, [15:8] run_count
   input  logic [1:0]  req_tuser,   // [1:0] run_status
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [8:0] line_index, [18:9] start_column,
                                    // [26:19] span_length, [34:27] color_value, zeros
   input  logic [1:0]  rsp_tuser,   // [1:0] span_kind
   input  logic        rsp_tlast,   // sprite_done
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatches,
   output int          outstanding
);

   // One predicted span.
   typedef struct packed {
      logic [8:0] line;
      logic [9:0] column;
      logic [7:0] length;
      logic [7:0] color;
      logic [1:0] kind;
      logic       done;
   } span_type;

   span_type expected_spans[$];

   // Register copies as the block should hold them.
   logic       cfg_mirror, cfg_full, cfg_shadow;
   logic [7:0] cfg_base;
   logic [9:0] cfg_width, cfg_skip;
   logic [8:0] cfg_height;

   // Traversal state of the sprite being drawn.
   logic [9:0] skip_left, width_left, column_pos;
   logic [8:0] lines_left, current_line;
   logic       draining, finished;

   // Reloads clipping, width and start column for a new line.
   function automatic void load_line();
      logic [9:0] w;
      w = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
      skip_left  = cfg_skip;
      width_left = w;
      column_pos = cfg_mirror ? w : 10'd0;
      draining   = 1'b0;
   endfunction

   // Advances to the next line; returns one when the sprite is over.
   function automatic logic close_line(logic [1:0] status);
      logic done;
      done = (status == ST_EOS) || (lines_left <= 9'd1);
      if (lines_left != 9'd0) lines_left = lines_left - 9'd1;
      current_line = current_line + 9'd1;
      load_line();
      if (done) finished = 1'b1;
      return done;
   endfunction

   // Works out the span that one run packet gives and updates the traversal state.
   function automatic span_type predict_span(logic [7:0] pix, logic [7:0] cnt,
                                             logic [1:0] status_in);
      span_type   s;
      logic [1:0] status;
      logic [7:0] excess;
      logic       opaque;
      s = '0;
      status = (status_in == ST_RSVD) ? ST_MORE : status_in;
      // A packet after the end of a sprite starts the next one.
      if (finished) begin
         lines_left   = (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
         current_line = 9'd0;
         finished     = 1'b0;
         load_line();
      end
      s.line   = current_line;
      s.column = column_pos;
      if (draining) begin
         // Surplus packets of a full line; a nonzero status closes it.
         if (status != ST_MORE) s.done = close_line(status);
      end else if (skip_left != 10'd0 && {2'b00, cnt} <= skip_left) begin
         // The whole run falls in the clipped columns; its status is ignored.
         skip_left = skip_left - {2'b00, cnt};
      end else begin
         excess    = cnt - skip_left[7:0];
         skip_left = 10'd0;
         s.length  = ({2'b00, excess} < width_left) ? excess : width_left[7:0];
         width_left = width_left - {2'b00, s.length};
         opaque = (cfg_shadow && pix != 8'd0) || (cfg_full && pix != FULL_TRANSPARENT) ||
                  (!cfg_full && pix != 8'd0);
         if (opaque) begin
            if (cfg_shadow) begin
               s.kind = KIND_SHADOW;
            end else begin
               s.kind  = KIND_WRITE;
               s.color = cfg_full ? {pix[3:0], pix[7:4]} : pix + cfg_base - 8'd1;
            end
         end
         column_pos = cfg_mirror ? column_pos - {2'b00, s.length}
                                 : column_pos + {2'b00, s.length};
         if (width_left == 10'd0 && status == ST_MORE) begin
            draining = 1'b1;
         end else if (width_left == 10'd0 || status != ST_MORE) begin
            s.done = close_line(status);
         end
      end
      return s;
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: span %s expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      span_type want;
      if (reset) begin
         cfg_mirror = 1'b0; cfg_full = 1'b0; cfg_shadow = 1'b0; cfg_base = 8'd0;
         cfg_width = 10'd1; cfg_height = 9'd1; cfg_skip = 10'd0;
         skip_left = 10'd0; width_left = 10'd0; column_pos = 10'd0;
         lines_left = 9'd0; current_line = 9'd0;
         draining = 1'b0; finished = 1'b1;
         expected_spans.delete();
         mismatches = 0;
      end else begin
         // Register writes land at the access edge.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_MIRROR:     cfg_mirror = csr_pwdata[0];
               REG_FULL_COLOR: cfg_full   = csr_pwdata[0];
               REG_SHADOW:     cfg_shadow = csr_pwdata[0];
               REG_BASE_COLOR: cfg_base   = csr_pwdata[7:0];
               REG_WIDTH:      cfg_width  = csr_pwdata[9:0];
               REG_HEIGHT:     cfg_height = csr_pwdata[8:0];
               REG_SKIP:       cfg_skip   = csr_pwdata[9:0];
               default: ;
            endcase
         end
         // Each span beat is matched against the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_spans.size() == 0) begin
               mismatches++;
               $display("%0t: span beat expected none, actual %h kind %0d last %0b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = expected_spans.pop_front();
               compare_field("line", want.line, rsp_tdata[8:0]);
               compare_field("column", want.column, rsp_tdata[18:9]);
               compare_field("length", want.length, rsp_tdata[26:19]);
               compare_field("color", want.color, rsp_tdata[34:27]);
               compare_field("padding", 0, rsp_tdata[39:35]);
               compare_field("kind", want.kind, rsp_tuser);
               compare_field("done", want.done, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) begin
            expected_spans.push_back(predict_span(req_tdata[7:0], req_tdata[15:8], req_tuser));
         end
      end
      outstanding <= expected_spans.size();
   end

endmodule

FILE: dv/rle_sprite_span_compositor_tb.sv
// Testbench top for the run-length sprite span compositor: clock, reset, run stimulus, verdict.
// Depends on rssc_pkg, the block itself and rle_sprite_span_compositor_checker.
module rle_sprite_span_compositor_tb;
   import rssc_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_RUNS  = 1800;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [7:0] pixel_value, [15:8] run_count
   logic [1:0]  req_tuser = '0;    // [1:0] run_status
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [8:0] line_index, [18:9] start_column,
                                   // [26:19] span_length, [34:27] color_value, zeros
   logic [1:0]  rsp_tuser;         // [1:0] span_kind
   logic        rsp_tlast;         // sprite_done
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatches;
   int outstanding;
   int cycle_count = 0;
   int runs_sent = 0;
   bit src_burst = 1'b0;

   // Register copies that the run generator sizes its lines from.
   logic [9:0] cur_width, cur_skip;
   logic [8:0] cur_height;

   always #1 clock = ~clock;

   rle_sprite_span_compositor dut (.*);

   rle_sprite_span_compositor_checker span_checker (.*);

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Span sink: after each beat it holds tready low for a drawn number of cycles.
   int  sink_hold = 0;
   bit  sink_burst = 1'b0;
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_hold = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if ($urandom_range(0, 63) == 0) sink_burst = ~sink_burst;
         n = sink_burst ? 0 : $urandom_range(0, 11);
         if (n == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            sink_hold = n;
         end
      end else if (!rsp_tready) begin
         if (sink_hold <= 1) begin
            rsp_tready <= 1'b1;
            sink_hold = 0;
         end else begin
            sink_hold = sink_hold - 1;
         end
      end
   end

   // Offers one run beat after a drawn gap and waits until it is taken.
   task automatic send_run(logic [7:0] pix, logic [7:0] cnt, logic [1:0] status);
      int gap;
      gap = src_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {cnt, pix};
      req_tuser  <= status;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      runs_sent++;
   endtask

   // Stops sending and waits until every predicted span has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until the block is idle, then writes every register.
   task automatic set_config(logic mirror, logic full, logic shadow, logic [7:0] base,
                             logic [9:0] width, logic [8:0] height, logic [9:0] skip);
      wait_idle();
      csr_write(REG_MIRROR, {31'd0, mirror});
      csr_write(REG_FULL_COLOR, {31'd0, full});
      csr_write(REG_SHADOW, {31'd0, shadow});
      csr_write(REG_BASE_COLOR, {24'd0, base});
      csr_write(REG_WIDTH, {22'd0, width});
      csr_write(REG_HEIGHT, {23'd0, height});
      csr_write(REG_SKIP, {22'd0, skip});
      cur_width  = width;
      cur_height = height;
      cur_skip   = skip;
   endtask

   // One sprite line: runs that cover the clipped and visible columns, sometimes
   // with surplus runs to drain, sometimes cut short, now and then a stray status.
   task automatic send_line(int target, logic [1:0] last_status);
      int         covered, surplus, extra, cnt, r;
      bit         last;
      logic [1:0] st;
      logic [7:0] pix;
      covered = 0;
      extra   = 0;
      surplus = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      do begin
         if ($urandom_range(0, 7) == 0) begin
            cnt = $urandom_range(0, 255);
         end else begin
            cnt = $urandom_range(0, target / 2 + 2);
            if (cnt > 255) cnt = 255;
         end
         covered += cnt;
         last = (covered >= target && extra >= surplus) || ($urandom_range(0, 19) == 0);
         if (covered >= target) extra++;
         st = last ? last_status : ST_MORE;
         if ($urandom_range(0, 11) == 0) st = 2'($urandom_range(0, 3));
         r = $urandom_range(0, 7);
         pix = (r == 0) ? 8'h00 : (r == 1) ? FULL_TRANSPARENT : 8'($urandom_range(0, 255));
         send_run(pix, 8'(cnt), st);
      end while (!last);
   endtask

   task automatic send_sprite();
      int lines, line_max, w;
      line_max = (cur_height > 6) ? 6 : cur_height + 1;
      lines = $urandom_range(1, line_max);
      w = (cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
      for (int l = 0; l < lines; l++) begin
         if (l == lines - 1 && $urandom_range(0, 3) != 0) send_line(cur_skip + w, ST_EOS);
         else send_line(cur_skip + w, ST_EOL);
      end
   endtask

   initial begin
      int         base_runs, r;
      logic [9:0] w, s;
      logic [8:0] h;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: register defaults, one pixel wide, one line high.
      wait_idle();
      send_run(8'hFF, 8'hFF, ST_EOS);
      send_run(8'h00, 8'h00, ST_MORE);

      // Directed: left clipping with ignored status, a zero count, the unused
      // status code, draining of a full line and a second line.
      set_config(1'b0, 1'b0, 1'b0, 8'hFF, 10'd8, 9'd3, 10'd3);
      send_run(8'h05, 8'd2, ST_EOS);
      send_run(8'h05, 8'd0, ST_EOL);
      send_run(8'h12, 8'd4, ST_MORE);
      send_run(8'h00, 8'd10, ST_RSVD);
      send_run(8'h07, 8'd7, ST_MORE);
      send_run(8'h07, 8'd7, ST_EOL);
      send_run(8'hFF, 8'd255, ST_EOS);

      // Directed: mirrored 256-color sprite at full width.
      set_config(1'b1, 1'b1, 1'b0, 8'h00, MAX_WIDTH, 9'd2, 10'd0);
      send_run(8'hFF, 8'd255, ST_MORE);
      send_run(8'hA5, 8'd255, ST_MORE);
      send_run(8'h00, 8'd255, ST_MORE);
      send_run(8'h01, 8'd1, ST_EOS);

      // Directed: shadow sprite with zero width and zero height.
      set_config(1'b0, 1'b1, 1'b1, 8'h80, 10'd0, 9'd0, 10'd0);
      send_run(8'h00, 8'd5, ST_MORE);
      send_run(8'h03, 8'd3, ST_EOL);
      send_run(8'h80, 8'd1, ST_EOL);

      // Directed: shadow with transparency codes, full clipping, tallest sprite.
      set_config(1'b1, 1'b0, 1'b1, 8'h01, MAX_WIDTH, MAX_HEIGHT, MAX_WIDTH);
      send_run(8'h00, 8'd255, ST_EOL);
      send_run(8'hFF, 8'd255, ST_EOS);
      send_run(8'h01, 8'd200, ST_EOL);
      send_run(8'hFF, 8'd4, ST_EOS);

      // Random phases: fresh registers, then a few sprites of random content.
      base_runs = runs_sent;
      while (runs_sent - base_runs < RANDOM_RUNS) begin
         r = $urandom_range(0, 15);
         w = (r == 0) ? MAX_WIDTH : (r == 1) ? 10'd0 : 10'($urandom_range(1, 24));
         r = $urandom_range(0, 15);
         h = (r == 0) ? MAX_HEIGHT : (r == 1) ? 9'd0 : 9'($urandom_range(1, 5));
         r = $urandom_range(0, 15);
         if (r < 5) s = 10'd0;
         else if (r == 5) s = MAX_WIDTH;
         else s = 10'($urandom_range(0, (w + 4 > 640) ? 640 : w + 4));
         set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255)), w, h, s);
         src_burst = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) send_sprite();
      end

      // Drain the last spans and give the block time to settle.
      src_burst = 1'b0;
      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
